// ===== sv/chunked_occupancy_grid_top_macros.svh =====
// Assertion macros for the port checker of the occupancy grid.
`ifndef CHUNKED_OCCUPANCY_GRID_TOP_MACROS_SVH
`define CHUNKED_OCCUPANCY_GRID_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define COG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define COG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/cog_pkg.sv =====
// Package of types and constants for the chunked occupancy grid.
package cog_pkg;
    localparam int ChunkSlots   = 16;
    localparam int Layers       = 4;
    localparam int CellsPerSide = 64;
    localparam int SlotW        = $clog2(ChunkSlots);
    localparam int LayerW       = $clog2(Layers);
    localparam int CellW        = 2 * $clog2(CellsPerSide);
    localparam int BitAddrW     = SlotW + LayerW + CellW;
    localparam int BitDepth     = ChunkSlots * Layers * CellsPerSide * CellsPerSide;
    localparam int PosW         = 40;
    localparam int ChunkW       = 25;
    localparam int CellSzW      = 19;

    localparam logic [1:0] OP_WRITE       = 2'd0;
    localparam logic [1:0] OP_QUERY_CELL  = 2'd1;
    localparam logic [1:0] OP_QUERY_CHUNK = 2'd2;
    localparam logic [1:0] OP_RESERVED    = 2'd3;

    localparam logic [0:0] REG_CHUNK_SIZE = 1'd0;
    localparam logic [0:0] REG_CELL_SIZE  = 1'd1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIVX, S_DIVY, S_CELLX, S_CELLY,
        S_LOOKUP, S_READ, S_WAIT, S_WRITE, S_DONE
    } t_state;

    typedef struct packed {
        logic       start;
        logic [PosW-1:0] dividend;
        logic [PosW-1:0] divisor;
        logic       is_signed;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [PosW-1:0] quot;
        logic [PosW-1:0] rem;
    } t_div_rsp;
endpackage

// ===== sv/chunked_occupancy_grid_top.sv =====
// Chunked occupancy grid: set, clear and query of cells, and query of chunks, in a
// sparse chunk table. A cell beat runs four serial divisions (chunk x, chunk y,
// cell x, cell y) in one shared divider, then the lookup and the bit read-modify-write
// in states LOOKUP, READ, WAIT and WRITE. A chunk query skips the divisions.
// One beat is in flight at a time: input ready stays low until the result is taken.
// After reset a clearing pass zeroes the bit memory before any beat.
module chunked_occupancy_grid_top import cog_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [ChunkW-1:0]    i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_operation,
    input  logic signed [39:0]   i_pos_x,
    input  logic signed [39:0]   i_pos_y,
    input  logic [1:0]           i_layer,
    input  logic                 i_occupied,
    input  logic signed [31:0]   i_chunk_x,
    input  logic signed [31:0]   i_chunk_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_changed,
    output logic                 o_is_set,
    output logic                 o_allocated,
    output logic [63:0]          o_revision,
    output logic                 o_table_full
);
    // Configuration registers.
    logic [ChunkW-1:0]  r_chunk_sz;
    logic [CellSzW-1:0] r_cell_sz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_sz <= ChunkW'(6400);
            r_cell_sz  <= CellSzW'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHUNK_SIZE: r_chunk_sz <= i_cfg_data;
                REG_CELL_SIZE:  r_cell_sz  <= i_cfg_data[CellSzW-1:0];
                default: ;
            endcase
        end
    end

    // Slot table: small, kept in flip-flops with valid bits.
    logic [ChunkSlots-1:0] r_slot_v;
    logic [31:0]           r_slot_x [ChunkSlots];
    logic [31:0]           r_slot_y [ChunkSlots];
    logic [63:0]           r_slot_rev [ChunkSlots];

    // Captured beat.
    t_state              r_state, n_state;
    logic [1:0]          r_op;
    logic [PosW-1:0]     r_px, r_py;
    logic [LayerW-1:0]   r_layer;
    logic                r_occ;
    logic [31:0]         r_cx, r_cy;
    logic [PosW-1:0]     r_rx, r_ry;
    logic [5:0]          r_cellx, r_celly;
    logic                r_hit;
    logic [SlotW-1:0]    r_slot;
    logic                r_free_ok;
    logic [SlotW-1:0]    r_free;
    logic [BitAddrW:0]   r_clr;
    logic                r_ov, r_ochg, r_oset, r_oall, r_ofull;
    logic [63:0]         r_orev;

    t_div_req w_req;
    t_div_rsp w_rsp;
    cog_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    logic                w_we, w_wd, w_rd;
    logic [BitAddrW-1:0] w_addr;
    cog_bitram u_ram (.i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
                      .i_wdata(w_wd), .o_rdata(w_rd));

    logic [PosW-1:0] w_csz, w_lsz;
    assign w_csz = (r_chunk_sz == '0) ? PosW'(1) : PosW'(r_chunk_sz);
    assign w_lsz = (r_cell_sz == '0) ? PosW'(1) : PosW'(r_cell_sz);

    // Associative match and free-slot search over the slot table.
    logic             w_hit, w_free_ok;
    logic [SlotW-1:0] w_slot, w_free;
    logic [31:0]      w_kx, w_ky;
    assign w_kx = r_cx;
    assign w_ky = r_cy;
    always_comb begin
        w_hit = 1'b0; w_slot = '0; w_free_ok = 1'b0; w_free = '0;
        for (int i = ChunkSlots - 1; i >= 0; i--) begin
            if (r_slot_v[i] && r_slot_x[i] == w_kx && r_slot_y[i] == w_ky) begin
                w_hit = 1'b1; w_slot = SlotW'(i);
            end
            if (!r_slot_v[i]) begin
                w_free_ok = 1'b1; w_free = SlotW'(i);
            end
        end
    end

    logic w_accept;
    assign o_ready  = (r_state == S_IDLE) && !r_ov;
    assign w_accept = i_valid && o_ready;

    logic [5:0] w_clamp;
    assign w_clamp = (w_rsp.quot > PosW'(CellsPerSide - 1)) ? 6'(CellsPerSide - 1)
                                                            : w_rsp.quot[5:0];
    logic [SlotW-1:0] w_use;
    assign w_use = r_hit ? r_slot : r_free;
    logic w_can;
    assign w_can = r_hit || (r_occ && r_free_ok);

    always_comb begin
        n_state = r_state;
        w_req = '{start: 1'b0, dividend: r_px, divisor: w_csz, is_signed: 1'b1};
        w_we = 1'b0;
        w_wd = r_occ;
        w_addr = {w_use, r_layer, r_celly, r_cellx};
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1; w_wd = 1'b0; w_addr = r_clr[BitAddrW-1:0];
                if (r_clr == (BitAddrW+1)'(BitDepth - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_operation == OP_QUERY_CHUNK) n_state = S_LOOKUP;
                    else if (i_operation == OP_RESERVED || 32'(i_layer) >= Layers)
                        n_state = S_DONE;
                    else begin
                        n_state = S_DIVX;
                        w_req.start = 1'b1; w_req.dividend = i_pos_x;
                    end
                end
            end
            S_DIVX: if (w_rsp.done) begin
                n_state = S_DIVY; w_req.start = 1'b1; w_req.dividend = r_py;
            end
            S_DIVY: if (w_rsp.done) begin
                n_state = S_CELLX; w_req.start = 1'b1; w_req.dividend = r_rx;
                w_req.divisor = w_lsz; w_req.is_signed = 1'b0;
            end
            S_CELLX: if (w_rsp.done) begin
                n_state = S_CELLY; w_req.start = 1'b1; w_req.dividend = r_ry;
                w_req.divisor = w_lsz; w_req.is_signed = 1'b0;
            end
            S_CELLY: if (w_rsp.done) n_state = S_LOOKUP;
            S_LOOKUP: n_state = (r_op == OP_QUERY_CHUNK) ? S_DONE : S_READ;
            S_READ:  n_state = S_WAIT;
            S_WAIT:  n_state = S_WRITE;
            S_WRITE: begin
                w_we = (r_op == OP_WRITE) && w_can && (w_rd != r_occ) && r_hit
                     || (r_op == OP_WRITE) && !r_hit && r_occ && r_free_ok;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_slot_v <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (o_valid && i_ready) r_ov <= 1'b0;
            if (r_state == S_DONE) r_ov <= 1'b1;
            if (r_state == S_WRITE && r_op == OP_WRITE && !r_hit && r_occ && r_free_ok)
                r_slot_v[r_free] <= 1'b1;
        end
        if (w_accept) begin
            r_op <= i_operation; r_px <= i_pos_x; r_py <= i_pos_y;
            r_layer <= i_layer[LayerW-1:0]; r_occ <= i_occupied;
            r_cx <= i_chunk_x; r_cy <= i_chunk_y;
            r_ochg <= 1'b0; r_oset <= 1'b0; r_oall <= 1'b0; r_ofull <= 1'b0;
            r_orev <= '0;
        end
        if (r_state == S_DIVX && w_rsp.done) begin
            r_cx <= w_rsp.quot[31:0]; r_rx <= w_rsp.rem;
        end
        if (r_state == S_DIVY && w_rsp.done) begin
            r_cy <= w_rsp.quot[31:0]; r_ry <= w_rsp.rem;
        end
        if (r_state == S_CELLX && w_rsp.done) r_cellx <= w_clamp;
        if (r_state == S_CELLY && w_rsp.done) r_celly <= w_clamp;
        if (r_state == S_LOOKUP) begin
            r_hit <= w_hit; r_slot <= w_slot;
            r_free_ok <= w_free_ok; r_free <= w_free;
            if (r_op == OP_QUERY_CHUNK && w_hit) begin
                r_oall <= 1'b1; r_orev <= r_slot_rev[w_slot];
            end
        end
        if (r_state == S_WRITE) begin
            if (r_op == OP_QUERY_CELL) r_oset <= r_hit & w_rd;
            if (r_op == OP_WRITE) begin
                if (!r_hit && r_occ && !r_free_ok) r_ofull <= 1'b1;
                if (!r_hit && r_occ && r_free_ok) begin
                    // A fresh slot: its bits were cleared, so the write changes.
                    r_slot_x[r_free] <= r_cx; r_slot_y[r_free] <= r_cy;
                    r_slot_rev[r_free] <= 64'd1; r_ochg <= 1'b1;
                end else if (r_hit && w_rd != r_occ) begin
                    r_slot_rev[r_slot] <= r_slot_rev[r_slot] + 64'd1; r_ochg <= 1'b1;
                end
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_changed    = r_ochg;
    assign o_is_set     = r_oset;
    assign o_allocated  = r_oall;
    assign o_revision   = r_orev;
    assign o_table_full = r_ofull;
endmodule

// ===== sv/cog_div.sv =====
// Radix-2 restoring divider with floor semantics for signed dividends.
module cog_div import cog_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CntW = $clog2(PosW + 1);
    logic [PosW-1:0] r_q, n_q, r_r, n_r, r_d, n_d;
    logic            r_neg, n_neg, r_busy, n_busy, r_done, n_done;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [PosW:0]   w_trial;
    logic [PosW:0]   w_shift;

    always_comb begin
        n_q = r_q; n_r = r_r; n_d = r_d; n_neg = r_neg;
        n_busy = r_busy; n_cnt = r_cnt; n_done = 1'b0;
        w_shift = {r_r, r_q[PosW-1]};
        w_trial = w_shift - {1'b0, r_d};
        if (i_req.start) begin
            n_neg  = i_req.is_signed & i_req.dividend[PosW-1];
            n_q    = n_neg ? (~i_req.dividend + 1'b1) : i_req.dividend;
            n_r    = '0;
            n_d    = i_req.divisor;
            n_busy = 1'b1;
            n_cnt  = CntW'(PosW);
        end else if (r_busy) begin
            if (!w_trial[PosW]) begin
                n_r = w_trial[PosW-1:0];
                n_q = {r_q[PosW-2:0], 1'b1};
            end else begin
                n_r = w_shift[PosW-1:0];
                n_q = {r_q[PosW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_r   <= n_r;
        r_d   <= n_d;
        r_neg <= n_neg;
    end

    // Floor correction for negative dividends.
    always_comb begin
        o_rsp.done = r_done;
        if (r_neg && r_r != '0) begin
            o_rsp.quot = ~r_q;
            o_rsp.rem  = r_d - r_r;
        end else begin
            o_rsp.quot = r_neg ? (~r_q + 1'b1) : r_q;
            o_rsp.rem  = r_r;
        end
    end
endmodule

// ===== sv/cog_bitram.sv =====
// Single-port occupancy bit memory with a registered read.
module cog_bitram import cog_pkg::*; (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [BitAddrW-1:0] i_addr,
    input  logic                i_wdata,
    output logic                o_rdata
);
    logic r_mem [BitDepth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== sv/cog_checker.sv =====
// Port checker for the occupancy grid, bound to the top level.
`include "chunked_occupancy_grid_top_macros.svh"
module cog_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_changed,
    input logic        o_is_set,
    input logic        o_allocated,
    input logic        o_table_full,
    input logic [63:0] o_revision
);
    logic [3:0] w_flags;
    assign w_flags = {o_changed, o_is_set, o_allocated, o_table_full};

    `COG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_revision))
    `COG_ASSERT_IMP(a_one_flag, i_clk, i_rst_n, o_valid, $countones(w_flags) <= 1)
    `COG_ASSERT_IMP(a_rev_alloc, i_clk, i_rst_n, o_valid && !o_allocated, o_revision == 64'd0)
    `COG_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, o_valid, !o_ready)
endmodule

bind chunked_occupancy_grid_top cog_port_checker u_cog_port_checker (.*);

// ===== tb/cog_checker.sv =====
// Predictor and scoreboard for the chunked occupancy grid.
`timescale 1ns / 1ps
module cog_checker import cog_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [ChunkW-1:0]    i_cfg_data,
    input  logic                 i_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_operation,
    input  logic signed [39:0]   i_pos_x,
    input  logic signed [39:0]   i_pos_y,
    input  logic [1:0]           i_layer,
    input  logic                 i_occupied,
    input  logic signed [31:0]   i_chunk_x,
    input  logic signed [31:0]   i_chunk_y,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_changed,
    input  logic                 i_is_set,
    input  logic                 i_allocated,
    input  logic [63:0]          i_revision,
    input  logic                 i_table_full,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_results
);
    typedef struct packed {
        logic        changed;
        logic        is_set;
        logic        allocated;
        logic [63:0] revision;
        logic        table_full;
    } t_grid_answer;

    logic [ChunkW-1:0]  chunk_cm;
    logic [CellSzW-1:0] cell_cm;
    logic               used   [ChunkSlots];
    logic [31:0]        addr_x [ChunkSlots];
    logic [31:0]        addr_y [ChunkSlots];
    logic [63:0]        rev    [ChunkSlots];
    bit                 occ    [BitDepth];
    t_grid_answer       answers_due[$];

    // Floor division of a signed position; chunk address is the low 32 bits.
    function automatic void split_pos(input logic signed [39:0] p, input longint unsigned d,
                                      output logic [31:0] q, output longint unsigned r);
        longint signed v;
        longint signed qq;
        longint signed rr;
        v  = p;
        qq = v / longint'(d);
        rr = v % longint'(d);
        if (rr < 0) begin
            rr += d;
            qq -= 1;
        end
        q = qq[31:0];
        r = rr;
    endfunction

    function automatic int cell_axis(input longint unsigned r, input longint unsigned c);
        longint unsigned k;
        k = r / c;
        return (k > 63) ? 63 : int'(k);
    endfunction

    function automatic int slot_of(input logic [31:0] cx, input logic [31:0] cy);
        for (int i = 0; i < ChunkSlots; i++)
            if (used[i] && addr_x[i] == cx && addr_y[i] == cy) return i;
        return -1;
    endfunction

    function automatic t_grid_answer apply_beat();
        t_grid_answer a;
        longint unsigned csz;
        longint unsigned lsz;
        longint unsigned rx;
        longint unsigned ry;
        logic [31:0] cx;
        logic [31:0] cy;
        int s;
        int idx;
        a = '0;
        csz = (chunk_cm == 0) ? 1 : chunk_cm;
        lsz = (cell_cm == 0) ? 1 : cell_cm;
        if (i_operation == OP_QUERY_CHUNK) begin
            s = slot_of(i_chunk_x, i_chunk_y);
            if (s >= 0) begin
                a.allocated = 1'b1;
                a.revision  = rev[s];
            end
            return a;
        end
        if (!(i_operation inside {OP_WRITE, OP_QUERY_CELL}) || i_layer >= Layers) return a;
        split_pos(i_pos_x, csz, cx, rx);
        split_pos(i_pos_y, csz, cy, ry);
        s = slot_of(cx, cy);
        idx = cell_axis(ry, lsz) * CellsPerSide + cell_axis(rx, lsz);
        if (i_operation == OP_QUERY_CELL) begin
            if (s >= 0) a.is_set = occ[(s * Layers + i_layer) * 4096 + idx];
            return a;
        end
        if (s < 0) begin
            if (!i_occupied) return a;
            for (int i = 0; i < ChunkSlots; i++)
                if (!used[i]) begin
                    s = i;
                    break;
                end
            if (s < 0) begin
                a.table_full = 1'b1;
                return a;
            end
            used[s] = 1'b1;
            addr_x[s] = cx;
            addr_y[s] = cy;
            rev[s] = '0;
        end
        idx = (s * Layers + i_layer) * 4096 + idx;
        if (occ[idx] != i_occupied) begin
            occ[idx] = i_occupied;
            rev[s] += 1;
            a.changed = 1'b1;
        end
        return a;
    endfunction

    assign o_pending = answers_due.size();

    always @(posedge i_clk) begin
        t_grid_answer exp_a;
        if (!i_rst_n) begin
            chunk_cm <= 6400;
            cell_cm  <= 100;
            o_errors <= 0;
            o_results <= 0;
            for (int i = 0; i < ChunkSlots; i++) used[i] = 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_CHUNK_SIZE) chunk_cm <= i_cfg_data;
                else cell_cm <= i_cfg_data[CellSzW-1:0];
            end
            if (i_valid && i_in_ready) answers_due.push_back(apply_beat());
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result beat", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_a = answers_due.pop_front();
                    if (exp_a != {i_changed, i_is_set, i_allocated, i_revision, i_table_full})
                    begin
                        $display("%0t: expected chg=%b set=%b alloc=%b rev=%0d full=%b",
                                 $time, exp_a.changed, exp_a.is_set, exp_a.allocated,
                                 exp_a.revision, exp_a.table_full);
                        $display("%0t: actual   chg=%b set=%b alloc=%b rev=%0d full=%b",
                                 $time, i_changed, i_is_set, i_allocated, i_revision,
                                 i_table_full);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_chunked_occupancy_grid_top.sv =====
// Stimulus and verdict for the chunked occupancy grid testbench.
`timescale 1ns / 1ps
module tb_chunked_occupancy_grid_top;
    import cog_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [0:0]         i_cfg_index;
    logic [ChunkW-1:0]  i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_operation;
    logic signed [39:0] i_pos_x;
    logic signed [39:0] i_pos_y;
    logic [1:0]         i_layer;
    logic               i_occupied;
    logic signed [31:0] i_chunk_x;
    logic signed [31:0] i_chunk_y;
    logic               o_valid;
    logic               i_ready;
    logic               o_changed;
    logic               o_is_set;
    logic               o_allocated;
    logic [63:0]        o_revision;
    logic               o_table_full;
    int                 fail_count;
    int                 answers_pending;
    int                 result_beats;
    int                 beats_sent;
    bit                 hold_off;

    chunked_occupancy_grid_top uut (.*);

    cog_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_ready(o_ready), .i_operation, .i_pos_x, .i_pos_y,
        .i_layer, .i_occupied, .i_chunk_x, .i_chunk_y,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_changed(o_changed),
        .i_is_set(o_is_set), .i_allocated(o_allocated), .i_revision(o_revision),
        .i_table_full(o_table_full), .o_errors(fail_count),
        .o_pending(answers_pending), .o_results(result_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A 40 ms timeout: it covers the clearing pass after reset and all the cell
    // beats, with stalls on both sides, several times over.
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: mostly a random stall pattern, with stretches of full
    // throughput, and one long hold-off while the sender keeps offering beats
    // so that the block backs up and drops its input ready.
    initial begin
        int cyc;
        cyc = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (hold_off) i_ready <= 1'b0;
            else if ((cyc / 500) % 3 == 0) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    logic [ChunkW-1:0] cur_chunk;
    function automatic longint unsigned uut_chunk();
        return (cur_chunk == 0) ? 1 : cur_chunk;
    endfunction

    // Most positions are chosen relative to a small set of chunks so that the
    // slots fill, cells repeat and set/clear pairs actually flip bits.
    function automatic logic signed [39:0] pick_pos(input int chunk_idx);
        longint signed base;
        case ($urandom_range(0, 9))
            0: return 40'({$urandom, $urandom});
            1: return 40'sh80_0000_0000;
            2: return 40'sh7F_FFFF_FFFF;
            default: begin
                base = longint'(chunk_idx - 3) * longint'(uut_chunk());
                return 40'(base + longint'($urandom_range(0, 32'(uut_chunk() - 1))));
            end
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic signed [39:0] px,
                             input logic signed [39:0] py, input logic [1:0] ly,
                             input logic oc, input logic signed [31:0] cx,
                             input logic signed [31:0] cy);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_pos_x     <= px;
        i_pos_y     <= py;
        i_layer     <= ly;
        i_occupied  <= oc;
        i_chunk_x   <= cx;
        i_chunk_y   <= cy;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic random_beat();
        logic [1:0] op;
        int ci;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        ci = $urandom_range(0, 6);
        op = ($urandom_range(0, 19) == 0) ? OP_RESERVED : 2'($urandom_range(0, 2));
        qx = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'(ci - 3);
        qy = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 6) - 3);
        send_beat(op, pick_pos(ci), pick_pos($urandom_range(0, 6)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 2) != 0), qx, qy);
    endtask

    // Sender idles between bursts; when a gap falls the valid drops.
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 400)) @(negedge i_clk);
        end
    endtask

    task automatic drain_and_write(input logic [0:0] idx, input logic [ChunkW-1:0] val);
        i_valid <= 1'b0;
        while (answers_pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_CHUNK_SIZE) cur_chunk = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int wait_cyc;
        logic [ChunkW-1:0] chunk_sets [6];
        logic [ChunkW-1:0] cell_sets  [6];
        chunk_sets = '{6400, 1, 25'h1FF_FFFF, 0, 640, 3};
        cell_sets  = '{100, 1, 19'h7FFFF, 0, 10, 1};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_operation = '0; i_pos_x = '0; i_pos_y = '0;
        i_layer = '0; i_occupied = 1'b0; i_chunk_x = '0; i_chunk_y = '0;
        hold_off = 1'b0; beats_sent = 0; cur_chunk = 6400;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset sizes: extremes, every operation, unknown
        // operation, layer edges, clearing in an absent chunk, remainder edges.
        send_beat(OP_QUERY_CHUNK, 0, 0, 0, 0, 0, 0);
        send_beat(OP_WRITE, 0, 0, 0, 0, 0, 0);
        send_beat(OP_WRITE, 0, 0, 0, 1, 0, 0);
        send_beat(OP_WRITE, 0, 0, 0, 1, 0, 0);
        send_beat(OP_QUERY_CELL, 99, 99, 0, 0, 0, 0);
        send_beat(OP_QUERY_CHUNK, 0, 0, 0, 0, 0, 0);
        send_beat(OP_RESERVED, -1, -1, 3, 1, -1, -1);
        send_beat(OP_WRITE, -1, -1, 3, 1, 0, 0);
        send_beat(OP_QUERY_CHUNK, 0, 0, 0, 0, -1, -1);
        send_beat(OP_WRITE, 40'sh80_0000_0000, 40'sh7F_FFFF_FFFF, 2, 1, 0, 0);
        send_beat(OP_QUERY_CELL, 40'sh80_0000_0000, 40'sh7F_FFFF_FFFF, 2, 0, 0, 0);
        send_beat(OP_WRITE, -6400, 6399, 1, 1, 0, 0);
        send_beat(OP_WRITE, -6400, 6399, 1, 0, 0, 0);
        send_beat(OP_QUERY_CHUNK, 0, 0, 0, 0, -1, 0);
        send_beat(OP_QUERY_CHUNK, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_beat(OP_WRITE, 0, 0, 0, 0, 0, 0);
        send_beat(OP_QUERY_CHUNK, 0, 0, 0, 0, 0, 0);

        // Fill the table with fresh chunks, then overflow it.
        for (int k = 0; k < 18; k++)
            send_beat(OP_WRITE, 40'(k * 6400 + 1_000_000), 12_800_000, 0, 1, 0, 0);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain_and_write(REG_CHUNK_SIZE, chunk_sets[ph]);
                drain_and_write(REG_CELL_SIZE, cell_sets[ph]);
            end
            for (int n = 0; n < 105; n++) begin
                if (ph == 2 && n == 30) begin
                    // Long hold-off: the sender keeps going behind it.
                    hold_off = 1'b1;
                    fork
                        begin
                            wait_cyc = 0;
                            while (wait_cyc < 2000) begin
                                @(negedge i_clk);
                                wait_cyc++;
                            end
                            hold_off = 1'b0;
                        end
                    join_none
                end
                if (!hold_off) sender_gap();
                random_beat();
            end
        end

        i_valid <= 1'b0;
        while (answers_pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Sent %0d beats over six size settings; %0d results checked.",
                 beats_sent, result_beats);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/cog_pkg.sv
sv/cog_div.sv
sv/cog_bitram.sv
sv/chunked_occupancy_grid_top.sv
sv/cog_checker.sv
tb/cog_checker.sv
tb/tb_chunked_occupancy_grid_top.sv
